// ----- rtl/core/modexp_pkg.sv -----
// Package for the modular exponentiation block: widths, microcode and shared types.
`default_nettype none

package modexp_pkg;

    // Operand width; every datapath word and port field follows it.
    localparam int OPERAND_BITS = 31;
    localparam int CNT_W        = $clog2(OPERAND_BITS);
    localparam int PC_W         = 4;

    typedef logic [OPERAND_BITS-1:0] word_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [PC_W-1:0]         pc_t;

    localparam word_t MODULUS_RESET = OPERAND_BITS'(1000003);

    // Datapath operation of one microcode step
    typedef enum logic [3:0] {
        OP_NOP       = 4'd0,
        OP_LOAD      = 4'd1,
        OP_START_RED = 4'd2,
        OP_START_SQR = 4'd3,
        OP_START_MUL = 4'd4,
        OP_WB_BASE   = 4'd5,
        OP_WB_ACC    = 4'd6,
        OP_SHIFT     = 4'd7,
        OP_WRITE_OUT = 4'd8
    } op_t;

    // Jump condition: taken -> target, else fall through to pc + 1
    typedef enum logic [2:0] {
        COND_ALWAYS    = 3'd0,
        COND_NO_REQ    = 3'd1,
        COND_TRIVIAL   = 3'd2,
        COND_MUL_BUSY  = 3'd3,
        COND_BIT_CLEAR = 3'd4,
        COND_MORE_BITS = 3'd5,
        COND_OUT_BUSY  = 3'd6
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ctrl_word_t;

    // Program addresses
    localparam pc_t PC_IDLE     = 4'd0;
    localparam pc_t PC_TRIVIAL  = 4'd1;
    localparam pc_t PC_RED      = 4'd2;
    localparam pc_t PC_RED_WAIT = 4'd3;
    localparam pc_t PC_SQR      = 4'd4;
    localparam pc_t PC_SQR_WAIT = 4'd5;
    localparam pc_t PC_TEST     = 4'd6;
    localparam pc_t PC_MUL      = 4'd7;
    localparam pc_t PC_MUL_WAIT = 4'd8;
    localparam pc_t PC_SHIFT    = 4'd9;
    localparam pc_t PC_OUT      = 4'd10;
    localparam pc_t PC_RETURN   = 4'd11;

    // Control store
    function automatic ctrl_word_t ucode(pc_t pc);
        ctrl_word_t w;
        case (pc)
            PC_IDLE:     w = '{OP_LOAD,      COND_NO_REQ,    PC_IDLE};
            PC_TRIVIAL:  w = '{OP_NOP,       COND_TRIVIAL,   PC_OUT};
            PC_RED:      w = '{OP_START_RED, COND_ALWAYS,    PC_RED_WAIT};
            PC_RED_WAIT: w = '{OP_WB_BASE,   COND_MUL_BUSY,  PC_RED_WAIT};
            PC_SQR:      w = '{OP_START_SQR, COND_ALWAYS,    PC_SQR_WAIT};
            PC_SQR_WAIT: w = '{OP_WB_ACC,    COND_MUL_BUSY,  PC_SQR_WAIT};
            PC_TEST:     w = '{OP_NOP,       COND_BIT_CLEAR, PC_SHIFT};
            PC_MUL:      w = '{OP_START_MUL, COND_ALWAYS,    PC_MUL_WAIT};
            PC_MUL_WAIT: w = '{OP_WB_ACC,    COND_MUL_BUSY,  PC_MUL_WAIT};
            PC_SHIFT:    w = '{OP_SHIFT,     COND_MORE_BITS, PC_SQR};
            PC_OUT:      w = '{OP_WRITE_OUT, COND_OUT_BUSY,  PC_OUT};
            PC_RETURN:   w = '{OP_NOP,       COND_ALWAYS,    PC_IDLE};
            default:     w = '{OP_NOP,       COND_ALWAYS,    PC_IDLE};
        endcase
        return w;
    endfunction

    // Multiplier command and status
    typedef struct packed {
        logic  start;
        word_t x;
        word_t y;
    } mul_ctl_t;

    typedef struct packed {
        logic  busy;
        word_t prod;
    } mul_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/modexp_if.sv -----
// Valid/ready channel interfaces for config, request and response.
`default_nettype none

interface modexp_cfg_if
    import modexp_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t modulus;
    modport source (output valid, output modulus, input ready);
    modport sink (input valid, input modulus, output ready);
endinterface

interface modexp_req_if
    import modexp_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  req_type;
    word_t base;
    word_t exponent;
    modport source (output valid, output req_type, output base, output exponent, input ready);
    modport sink (input valid, input req_type, input base, input exponent, output ready);
endinterface

interface modexp_rsp_if
    import modexp_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t result;
    modport source (output valid, output result, input ready);
    modport sink (input valid, input result, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/modular_exponentiation_top.sv -----
// Top level: microcoded square-and-multiply modular exponentiation engine.
// ---------------------------------------------------------------------------
// Channels (valid/ready, transfer when both high at a rising clk edge):
//   cfg : writes the modulus; always ready. Write only while the block is idle.
//   req : req_type, base, exponent. req_type 1 replaces the exponent with
//         modulus - 2 (inverse for a prime modulus).
//   rsp : one result per request, held in an output register.
// Each set exponent bit adds a multiply; a zero exponent or a modulus below
//   two skips the multiplier and goes straight to the output step.
// Run time is set by the single bit-serial multiplier (one multiplier bit
//   per cycle), shared by base reduction, squaring and multiplying.
// One request is processed at a time; req.ready is high only in the idle step.
// A finished result waits in the output register; if rsp stalls, the next
//   request runs and the sequencer holds at the output step until the slot
//   frees up.
// Reset: modulus returns to 1000003, sequencer to idle, output slot empty.
// ---------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_top
    import modexp_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    modexp_cfg_if.sink   cfg,
    modexp_req_if.sink   req,
    modexp_rsp_if.source rsp
);

    // Sequencer state
    pc_t        pc_reg, pc_next;
    ctrl_word_t uword;
    logic       jump;

    // Datapath registers
    word_t modulus_reg;
    word_t acc_reg, acc_next;
    word_t base_reg, base_next;
    word_t exp_reg, exp_next;
    cnt_t  cnt_reg, cnt_next;
    logic  rsp_valid_reg, rsp_valid_next;
    word_t result_reg, result_next;

    word_t     eff_exp;
    logic      accept;
    logic      out_busy;
    mul_ctl_t  mul_ctl;
    mul_stat_t mul_stat;

    assign uword    = ucode(pc_reg);
    assign accept   = (uword.op == OP_LOAD) && req.valid;
    assign out_busy = rsp_valid_reg && !rsp.ready;

    // Inverse requests: exponent = modulus - 2, wrapping at the word width
    assign eff_exp = req.req_type ? (modulus_reg - word_t'(2)) : req.exponent;

    // Branch condition select
    always_comb
    begin
        case (uword.cond)
            COND_ALWAYS:    jump = 1'b1;
            COND_NO_REQ:    jump = !req.valid;
            COND_TRIVIAL:   jump = (exp_reg == '0) || (modulus_reg < word_t'(2));
            COND_MUL_BUSY:  jump = mul_stat.busy;
            COND_BIT_CLEAR: jump = !exp_reg[OPERAND_BITS-1];
            COND_MORE_BITS: jump = (cnt_reg != '0);
            COND_OUT_BUSY:  jump = out_busy;
            default:        jump = 1'b1;
        endcase
    end

    assign pc_next = jump ? uword.target : pc_reg + pc_t'(1);

    // Multiplier operands: reduction is 1 * base, squaring acc * acc, multiplying base * acc
    always_comb
    begin
        mul_ctl.start = (uword.op == OP_START_RED) || (uword.op == OP_START_SQR)
                     || (uword.op == OP_START_MUL);
        case (uword.op)
            OP_START_RED:
            begin
                mul_ctl.x = word_t'(1);
                mul_ctl.y = base_reg;
            end
            OP_START_SQR:
            begin
                mul_ctl.x = acc_reg;
                mul_ctl.y = acc_reg;
            end
            default:
            begin
                mul_ctl.x = base_reg;
                mul_ctl.y = acc_reg;
            end
        endcase
    end

    modexp_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (modulus_reg),
        .ctl     (mul_ctl),
        .status  (mul_stat)
    );

    // Datapath writes per control word
    always_comb
    begin
        acc_next       = acc_reg;
        base_next      = base_reg;
        exp_next       = exp_reg;
        cnt_next       = cnt_reg;
        result_next    = result_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        case (uword.op)
            OP_LOAD:
            begin
                if (accept)
                begin
                    base_next = req.base;
                    exp_next  = eff_exp;
                    cnt_next  = cnt_t'(OPERAND_BITS - 1);
                    // zero exponent -> 1; otherwise modulus 0 or 1 -> 0
                    acc_next  = ((eff_exp == '0) || (modulus_reg >= word_t'(2)))
                                ? word_t'(1) : '0;
                end
            end
            OP_WB_BASE:
            begin
                if (!mul_stat.busy)
                begin
                    base_next = mul_stat.prod;
                end
            end
            OP_WB_ACC:
            begin
                if (!mul_stat.busy)
                begin
                    acc_next = mul_stat.prod;
                end
            end
            OP_SHIFT:
            begin
                exp_next = {exp_reg[OPERAND_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - cnt_t'(1);
            end
            OP_WRITE_OUT:
            begin
                if (!out_busy)
                begin
                    result_next    = acc_reg;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_IDLE;
            rsp_valid_reg <= 1'b0;
            modulus_reg   <= MODULUS_RESET;
            cnt_reg       <= '0;
        end
        else
        begin
            pc_reg        <= pc_next;
            rsp_valid_reg <= rsp_valid_next;
            cnt_reg       <= cnt_next;
            if (cfg.valid)
            begin
                modulus_reg <= cfg.modulus;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        base_reg   <= base_next;
        exp_reg    <= exp_next;
        result_reg <= result_next;
    end

    assign cfg.ready  = 1'b1;
    assign req.ready  = (uword.op == OP_LOAD);
    assign rsp.valid  = rsp_valid_reg;
    assign rsp.result = result_reg;

    // The multiplier only runs while the sequencer sits in a wait step
    a_mul_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_stat.busy |-> (uword.op == OP_WB_BASE || uword.op == OP_WB_ACC))
        else $error("multiplier busy outside a wait step");

    // Every finished product is fully reduced
    a_prod_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(mul_stat.busy) |-> (mul_stat.prod < modulus_reg))
        else $error("multiplier product not reduced");

    // An accepted request moves straight to the trivial-case check
    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (pc_reg == PC_TRIVIAL))
        else $error("sequencer did not advance after accept");

    // A new multiply never starts while one is running
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        mul_ctl.start |-> !mul_stat.busy)
        else $error("multiplier restarted while busy");

endmodule

`default_nettype wire

// ----- rtl/core/modexp_mul.sv -----
// Bit-serial interleaved modular multiplier: prod = x * y mod modulus, x < modulus.
`default_nettype none

module modexp_mul
    import modexp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire word_t modulus,
    input  wire mul_ctl_t ctl,
    output mul_stat_t status
);

    localparam int SUM_W = OPERAND_BITS + 2;

    logic busy_reg, busy_next;
    cnt_t cnt_reg, cnt_next;
    word_t r_reg, r_next;
    word_t x_reg, x_next;
    word_t y_reg, y_next;

    logic [SUM_W-1:0] sum, m1, m2, red;

    // r = 2r + ybit * x, then bring back below m (sum < 3m)
    always_comb
    begin
        m1  = {2'b00, modulus};
        m2  = {1'b0, modulus, 1'b0};
        sum = {1'b0, r_reg, 1'b0} + (y_reg[OPERAND_BITS-1] ? {2'b00, x_reg} : '0);
        if (sum >= m2)
        begin
            red = sum - m2;
        end
        else if (sum >= m1)
        begin
            red = sum - m1;
        end
        else
        begin
            red = sum;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = cnt_t'(OPERAND_BITS - 1);
            r_next    = '0;
            x_next    = ctl.x;
            y_next    = ctl.y;
        end
        else if (busy_reg)
        begin
            r_next = red[OPERAND_BITS-1:0];
            y_next = {y_reg[OPERAND_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - cnt_t'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        x_reg <= x_next;
        y_reg <= y_next;
    end

    assign status.busy = busy_reg;
    assign status.prod = r_reg;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for modular_exponentiation_top: directed and random requests checked by a scoreboard.
`timescale 1ns / 100ps

module tb
    import modexp_pkg::*;
();

    // Request types on req.req_type
    localparam logic REQ_POWER   = 1'b0;
    localparam logic REQ_INVERSE = 1'b1;

    localparam int     CLK_HALF      = 4;
    localparam int     RESET_CYCLES  = 10;
    localparam int     RANDOM_ITEMS  = 1450;
    localparam int     SEGMENT_ITEMS = 50;       // requests per modulus setting
    localparam int     LONG_HOLD     = 10000;    // length of the long rsp stall
    localparam int     SETTLE_CYCLES = 16;
    localparam int     MAX_REPORTS   = 10;
    localparam longint TIMEOUT_NS    = 64'd150_000_000;
    localparam word_t  WORD_MAX      = '1;

    // Prime moduli for the random segments; both ends of the modulus range included.
    localparam word_t PRIMES [10] = '{
        word_t'(2), word_t'(3), word_t'(5), word_t'(7), word_t'(251), word_t'(65521),
        word_t'(65537), word_t'(1000003), word_t'(998244353), word_t'(2147483647)
    };

    // -----------------------------------------------------------------------
    // Scoreboard: own copy of the modulus, computes each expected result when a
    // request is accepted and compares results in order.
    // -----------------------------------------------------------------------
    class modexp_scoreboard;
        word_t       modulus;
        word_t       expected_results[$];
        int unsigned failures;

        function new();
            modulus  = MODULUS_RESET;
            failures = 0;
        endfunction

        // Square and multiply from the top exponent bit down; base only
        // enters through the reduced products.
        function word_t power_mod(word_t b, word_t e, word_t m);
            longint unsigned acc;
            if (e == '0)
                return word_t'(1);
            if (m == '0)
                return '0;
            acc = 1;
            for (int i = OPERAND_BITS - 1; i >= 0; i--)
            begin
                acc = (acc * acc) % longint'(m);
                if (e[i])
                    acc = (acc * longint'(b)) % longint'(m);
            end
            return word_t'(acc);
        endfunction

        function void note_request(logic kind, word_t b, word_t e);
            word_t exp_used;
            // inverse: exponent is modulus - 2, wrapping for modulus below two
            exp_used = (kind == REQ_INVERSE) ? word_t'(modulus - word_t'(2)) : e;
            expected_results = {expected_results, power_mod(b, exp_used, modulus)};
        endfunction

        function void check_result(word_t got);
            word_t want;
            if (expected_results.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("result %0d arrived with no request outstanding", got);
                return;
            end
            want = expected_results.pop_front();
            if (got !== want)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("result error: expected %0d, got %0d", want, got);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    modexp_cfg_if cfg();
    modexp_req_if req();
    modexp_rsp_if rsp();

    modexp_scoreboard sb = new();

    int unsigned send_idle_pct;    // chance of a gap before each request
    int unsigned recv_idle_pct;    // chance of rsp.ready low in a cycle
    logic        rsp_hold;         // long rsp stall in progress

    modular_exponentiation_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    // Response side: check on accepted results, then pick ready for the next edge.
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_result(rsp.result);
        if (rsp_hold)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one request, with an optional gap first; returns at the accepting edge.
    task automatic send_request(input logic kind, input word_t base_val, input word_t exp_val);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid    <= 1'b1;
        req.req_type <= kind;
        req.base     <= base_val;
        req.exponent <= exp_val;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sb.note_request(kind, base_val, exp_val);
    endtask

    // Stop offering and wait until every outstanding request has its result.
    task automatic drain_results();
        req.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only called with the engine idle (after drain_results).
    task automatic write_modulus(input word_t value);
        cfg.valid   <= 1'b1;
        cfg.modulus <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        sb.modulus = value;
    endtask

    // Random request: base and exponent mix the edges of the range with
    // full-width values; about a quarter are inverse requests.
    task automatic send_random_request();
        logic  kind;
        word_t b;
        word_t e;
        kind = ($urandom_range(3) == 0) ? REQ_INVERSE : REQ_POWER;
        case ($urandom_range(9))
            0:       b = '0;
            1:       b = word_t'(1);
            2:       b = WORD_MAX;
            3, 4:    b = (sb.modulus > 1) ? word_t'($urandom_range(sb.modulus - 1))
                                          : word_t'($urandom);
            default: b = word_t'($urandom);
        endcase
        case ($urandom_range(9))
            0:       e = '0;
            1:       e = WORD_MAX;
            2, 3:    e = word_t'($urandom_range(64));
            default: e = word_t'($urandom);
        endcase
        send_request(kind, b, e);
    endtask

    initial
    begin
        word_t mod_val;
        int    idx;

        req.valid     = 1'b0;
        req.req_type  = REQ_POWER;
        req.base      = '0;
        req.exponent  = '0;
        cfg.valid     = 1'b0;
        cfg.modulus   = MODULUS_RESET;
        rsp_hold      = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n         = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: reset modulus 1000003, no write yet ---
        send_request(REQ_POWER, '0, '0);                  // zero exponent gives 1
        send_request(REQ_POWER, '0, word_t'(5));
        send_request(REQ_POWER, WORD_MAX, WORD_MAX);
        send_request(REQ_POWER, word_t'(1), WORD_MAX);
        send_request(REQ_POWER, WORD_MAX, word_t'(1));     // base above modulus, unreduced
        send_request(REQ_POWER, word_t'(1000003), word_t'(3));
        send_request(REQ_INVERSE, word_t'(2), '0);
        send_request(REQ_INVERSE, WORD_MAX, WORD_MAX);     // exponent field ignored
        send_request(REQ_INVERSE, '0, word_t'(1));
        drain_results();

        // largest prime modulus
        write_modulus(WORD_MAX);
        send_request(REQ_POWER, WORD_MAX, word_t'(9));
        send_request(REQ_POWER, WORD_MAX - word_t'(1), word_t'(2));
        send_request(REQ_INVERSE, word_t'(3), '0);
        drain_results();

        // smallest valid modulus
        write_modulus(word_t'(2));
        send_request(REQ_POWER, word_t'(3), WORD_MAX);
        send_request(REQ_INVERSE, word_t'(1), '0);         // exponent becomes zero
        drain_results();

        // modulus one: nonzero exponent gives 0, zero exponent still 1
        write_modulus(word_t'(1));
        send_request(REQ_POWER, word_t'(5), '0);
        send_request(REQ_POWER, word_t'(5), word_t'(4));
        send_request(REQ_INVERSE, word_t'(5), '0);         // exponent wraps
        drain_results();

        // modulus zero
        write_modulus('0);
        send_request(REQ_POWER, word_t'(7), '0);
        send_request(REQ_POWER, word_t'(7), word_t'(7));
        send_request(REQ_INVERSE, word_t'(7), '0);
        drain_results();

        // non-prime modulus: inverse request is just a power
        write_modulus(word_t'(1000000));
        send_request(REQ_INVERSE, word_t'(3), '0);
        send_request(REQ_POWER, word_t'(10), word_t'(6));
        drain_results();

        // --- random: one modulus per segment, engine drained between segments ---
        for (int seg = 0; seg * SEGMENT_ITEMS < RANDOM_ITEMS; seg++)
        begin
            case ($urandom_range(19))
                0:              mod_val = word_t'($urandom_range(1));
                1, 2, 3:        mod_val = word_t'($urandom_range(1000, 2));
                4, 5, 6, 7:     mod_val = word_t'($urandom);
                default:        mod_val = PRIMES[$urandom_range(9)];
            endcase
            write_modulus(mod_val);
            for (int n = 0; n < SEGMENT_ITEMS; n++)
            begin
                idx = seg * SEGMENT_ITEMS + n;
                // idle mix: slow receiver, then slow sender, then full rate
                if (idx < RANDOM_ITEMS / 3)
                begin
                    send_idle_pct = 29;
                    recv_idle_pct <= 66;
                end
                else if (idx < 2 * RANDOM_ITEMS / 3)
                begin
                    send_idle_pct = 66;
                    recv_idle_pct <= 29;
                end
                else
                begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
                // long rsp stall while requests keep coming: output slot and
                // sequencer fill up and req.ready stays low
                if (idx == 10 || idx == 1000)
                    fork
                        begin
                            rsp_hold <= 1'b1;
                            repeat (LONG_HOLD) @(posedge clk);
                            rsp_hold <= 1'b0;
                        end
                    join_none
                send_random_request();
            end
            drain_results();
        end

        if (sb.failures == 0 && sb.pending() == 0)
            $display("modular_exponentiation_top: match");
        else
            $display("modular_exponentiation_top: mismatch");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin
        #(TIMEOUT_NS);
        $display("modular_exponentiation_top: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/modexp_pkg.sv
rtl/core/modexp_if.sv
rtl/core/modexp_mul.sv
rtl/core/modular_exponentiation_top.sv
tb/tb.sv
